// ===== rtl/plc_pkg.sv =====
// Shared types and constants for the pixel layer combiner.
package plc_pkg;

  // Lane layout: red, green, blue, then alpha
  localparam int PLC_LANES = 4;
  localparam int LANE_ALPHA = 3;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BLUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 3'd4;

  localparam logic [7:0] FILTER_RESET = 8'd255;
  localparam logic [7:0] BYTE_MAX = 8'd255;

  // Blend mode codes
  typedef enum logic [3:0] {
    MODE_ADDCLAMP  = 4'd0,
    MODE_ADDWRAP   = 4'd1,
    MODE_SUBCLAMP  = 4'd2,
    MODE_SUBWRAP   = 4'd3,
    MODE_MUL       = 4'd4,
    MODE_MULDOUBLE = 4'd5,
    MODE_BLEND     = 4'd6,
    MODE_ALPHA     = 4'd7,
    MODE_LAYER     = 4'd8
  } plc_mode_t;

  // Request payload
  typedef struct packed {
    logic [7:0] target_red;
    logic [7:0] target_green;
    logic [7:0] target_blue;
    logic [7:0] target_alpha;
    logic [7:0] layer_red;
    logic [7:0] layer_green;
    logic [7:0] layer_blue;
    logic [7:0] layer_alpha;
  } plc_in_t;

  // Result payload
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } plc_out_t;

  // Per-lane data after the product stage
  typedef struct packed {
    logic [7:0]  t;     // target byte
    logic [7:0]  s;     // filtered layer byte
    logic [15:0] pl;    // layer weight product
    logic [15:0] pt;    // target weight product
  } plc_s1_t;

  // Per-lane data after the combine stage
  typedef struct packed {
    logic [7:0]  t;
    logic [8:0]  sum;   // t + s
    logic [8:0]  diff;  // t - s, bit 8 set when negative
    logic [15:0] prod;  // t * s
    logic [15:0] x;     // composite numerator
    logic [7:0]  q0;    // estimate of x / 255, low by at most one
  } plc_s2_t;

endpackage

// ===== rtl/pixel_layer_combiner.sv =====
// Pixel layer combiner: three-stage pipelined RGBA blend with nine modes.
// A request taken at a clock edge passes the s1 and s2 registers into result,
// where done flags it; one pixel per clock, busy stays low and nothing stalls.
// Stage one holds the 8x8 multiplies, stage two the adds and the t*s multiply
// with the divide-by-255 estimate, stage three the mode select and correction.
// Reset empties the pipeline and sets layer mode with all filter bytes at 255.
module pixel_layer_combiner
  import plc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  plc_in_t               pixel,
  output logic                  done,
  output plc_out_t              result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [3:0] mode;
  logic [7:0] filter_red;
  logic [7:0] filter_green;
  logic [7:0] filter_blue;
  logic [7:0] filter_alpha;

  plc_mode_t mode_eff;

  // Pipeline registers
  logic      v1;
  logic      v2;
  plc_mode_t m1;
  plc_mode_t m2;
  plc_s1_t   s1      [PLC_LANES];
  plc_s2_t   s2      [PLC_LANES];
  plc_s1_t   s1_next [PLC_LANES];
  plc_s2_t   s2_next [PLC_LANES];
  plc_out_t  result_next;

  logic [7:0]  tv   [PLC_LANES];
  logic [7:0]  fop  [PLC_LANES];
  logic [7:0]  fv   [PLC_LANES];
  logic [7:0]  lop  [PLC_LANES];
  logic [15:0] rem  [PLC_LANES];
  logic [7:0]  lane_res [PLC_LANES];

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Unused codes fall back to layer compositing
  assign mode_eff = (mode > 4'(MODE_LAYER)) ? MODE_LAYER : plc_mode_t'(mode);

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 4'(MODE_LAYER);
      filter_red   <= FILTER_RESET;
      filter_green <= FILTER_RESET;
      filter_blue  <= FILTER_RESET;
      filter_alpha <= FILTER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:         mode         <= cfg_data[3:0];
        CFG_FILTER_RED:   filter_red   <= cfg_data[7:0];
        CFG_FILTER_GREEN: filter_green <= cfg_data[7:0];
        CFG_FILTER_BLUE:  filter_blue  <= cfg_data[7:0];
        CFG_FILTER_ALPHA: filter_alpha <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Route operands to lanes; alpha lane filters layer alpha and composites 255
  always_comb begin
    tv[0] = pixel.target_red;
    tv[1] = pixel.target_green;
    tv[2] = pixel.target_blue;
    tv[3] = pixel.target_alpha;
    fop[0] = pixel.layer_red;
    fop[1] = pixel.layer_green;
    fop[2] = pixel.layer_blue;
    fop[3] = pixel.layer_alpha;
    fv[0] = filter_red;
    fv[1] = filter_green;
    fv[2] = filter_blue;
    fv[3] = filter_alpha;
    lop[0] = pixel.layer_red;
    lop[1] = pixel.layer_green;
    lop[2] = pixel.layer_blue;
    lop[3] = BYTE_MAX;
  end

  // Stage one: filter and weight products
  always_comb begin
    logic [15:0] sprod;
    for (int i = 0; i < PLC_LANES; i++) begin
      sprod         = 16'(fop[i]) * 16'(fv[i]);
      s1_next[i].t  = tv[i];
      s1_next[i].s  = sprod[15:8];
      s1_next[i].pl = 16'(lop[i]) * 16'(pixel.layer_alpha);
      s1_next[i].pt = 16'(tv[i]) * 16'(BYTE_MAX - pixel.layer_alpha);
    end
  end

  // Stage two: sums, difference, product and quotient estimate
  always_comb begin
    logic [16:0] xq;
    for (int i = 0; i < PLC_LANES; i++) begin
      s2_next[i].t    = s1[i].t;
      s2_next[i].sum  = {1'b0, s1[i].t} + {1'b0, s1[i].s};
      s2_next[i].diff = {1'b0, s1[i].t} - {1'b0, s1[i].s};
      s2_next[i].prod = 16'(s1[i].t) * 16'(s1[i].s);
      s2_next[i].x    = s1[i].pl + s1[i].pt;
      // floor(x * 257 / 65536) undershoots x / 255 by at most one
      xq              = 17'(s2_next[i].x) + 17'(s2_next[i].x[15:8]);
      s2_next[i].q0   = xq[15:8];
    end
  end

  // Stage three: correct the quotient and select by mode
  always_comb begin
    logic [7:0] q;
    for (int i = 0; i < PLC_LANES; i++) begin
      rem[i] = s2[i].x - {s2[i].q0, 8'd0} + 16'(s2[i].q0);
      q      = (rem[i] >= 16'(BYTE_MAX)) ? s2[i].q0 + 8'd1 : s2[i].q0;
      case (m2)
        MODE_ADDCLAMP:
          lane_res[i] = (s2[i].sum >= 9'(BYTE_MAX)) ? BYTE_MAX : s2[i].sum[7:0];
        MODE_ADDWRAP:
          lane_res[i] = (s2[i].sum >= 9'(BYTE_MAX)) ? 8'(s2[i].sum - 9'(BYTE_MAX))
                                                    : s2[i].sum[7:0];
        MODE_SUBCLAMP:
          lane_res[i] = s2[i].diff[8] ? 8'd0 : s2[i].diff[7:0];
        MODE_SUBWRAP:
          // A full 255 wraps to zero; a negative difference keeps its low byte
          lane_res[i] = (!s2[i].diff[8] && s2[i].diff[7:0] == BYTE_MAX) ? 8'd0
                                                                     : s2[i].diff[7:0];
        MODE_MUL:
          lane_res[i] = s2[i].prod[15:8];
        MODE_MULDOUBLE:
          lane_res[i] = (s2[i].prod[15:7] >= 9'(BYTE_MAX)) ? BYTE_MAX
                                                           : s2[i].prod[14:7];
        MODE_BLEND:
          lane_res[i] = s2[i].sum[8:1];
        MODE_ALPHA:
          lane_res[i] = (i == LANE_ALPHA) ? s2[i].sum[8:1] : s2[i].t;
        default:
          lane_res[i] = q;
      endcase
      // Target alpha passes through in the color modes
      if (i == LANE_ALPHA && m2 != MODE_ALPHA && m2 != MODE_LAYER) begin
        lane_res[i] = s2[i].t;
      end
    end
    result_next.out_red   = lane_res[0];
    result_next.out_green = lane_res[1];
    result_next.out_blue  = lane_res[2];
    result_next.out_alpha = lane_res[3];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      done <= v2;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    m1     <= mode_eff;
    m2     <= m1;
    result <= result_next;
    for (int i = 0; i < PLC_LANES; i++) begin
      s1[i] <= s1_next[i];
      s2[i] <= s2_next[i];
    end
  end

  // Every request yields a result with done; none is lost in the pipeline
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("request lost in pipeline");

  // No result without a request
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result without request");

  // Quotient estimate is never low by more than one
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (rem[0] < 16'd510 && rem[1] < 16'd510 &&
            rem[2] < 16'd510 && rem[3] < 16'd510))
    else $error("divide by 255 estimate out of range");

  // Opaque layer in layer mode replaces the target
  a_opaque_layer: assert property (@(posedge clk) disable iff (rst)
    (done && $past(accept && mode_eff == MODE_LAYER &&
                   pixel.layer_alpha == BYTE_MAX, 3))
    |-> (result.out_red == $past(pixel.layer_red, 3) &&
         result.out_alpha == BYTE_MAX))
    else $error("opaque composite mismatch");

endmodule

// ===== tb/pixel_layer_combiner_tb.sv =====
// Self-checking testbench for the pixel layer combiner blend pipeline.
module pixel_layer_combiner_tb
  import plc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 3;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_COUNT = 16;
  localparam int PHASE_ITEMS = 50;
  // A mode code past the last defined one; the block treats it as layer mode
  localparam logic [3:0] MODE_CODE_UNUSED = 4'd12;

  // Expected-pixel tracker: mirrors the registers and queues predicted pixels
  class blend_scoreboard;
    logic [3:0] mode_reg;
    logic [7:0] filt_red;
    logic [7:0] filt_green;
    logic [7:0] filt_blue;
    logic [7:0] filt_alpha;
    plc_out_t pending[$];
    int unsigned mismatches;
    int unsigned compared;

    function new();
      mode_reg = MODE_LAYER;
      filt_red = FILTER_RESET;
      filt_green = FILTER_RESET;
      filt_blue = FILTER_RESET;
      filt_alpha = FILTER_RESET;
      mismatches = 0;
      compared = 0;
    endfunction

    // Track a register write; unknown indexes are dropped
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE:         mode_reg = data[3:0];
        CFG_FILTER_RED:   filt_red = data;
        CFG_FILTER_GREEN: filt_green = data;
        CFG_FILTER_BLUE:  filt_blue = data;
        CFG_FILTER_ALPHA: filt_alpha = data;
        default: ;
      endcase
    endfunction

    // One color lane: filter the layer byte and combine it with the target; layer mode uses the unfiltered byte
    function int unsigned blend_lane(plc_mode_t m, int unsigned t, int unsigned l,
                                     int unsigned f, int unsigned la);
      int unsigned s;
      int unsigned v;
      s = (l * f) >> 8;
      case (m)
        MODE_ADDCLAMP: begin
          v = t + s;
          return (v < 255) ? v : 255;
        end
        MODE_ADDWRAP:  return (t + s) % 255;
        MODE_SUBCLAMP: return (t > s) ? t - s : 0;
        MODE_SUBWRAP: begin
          if (t >= s) return (t - s) % 255;
          // negative remainder folded back into a byte
          return (256 - (s - t) % 255) & 8'hFF;
        end
        MODE_MUL: return (t * s) >> 8;
        MODE_MULDOUBLE: begin
          v = (t * s) >> 7;
          return (v < 255) ? v : 255;
        end
        MODE_BLEND: return (t + s) >> 1;
        MODE_ALPHA: return t;
        default:    return (l * la + t * (255 - la)) / 255;
      endcase
    endfunction

    // Predict the pixel for an accepted request
    function void note_request(plc_in_t p);
      plc_mode_t eff;
      plc_out_t e;
      int unsigned ta;
      int unsigned la;
      eff = (mode_reg > 4'(MODE_LAYER)) ? MODE_LAYER : plc_mode_t'(mode_reg);
      ta = p.target_alpha;
      la = p.layer_alpha;
      e.out_red   = 8'(blend_lane(eff, p.target_red, p.layer_red, filt_red, la));
      e.out_green = 8'(blend_lane(eff, p.target_green, p.layer_green, filt_green, la));
      e.out_blue  = 8'(blend_lane(eff, p.target_blue, p.layer_blue, filt_blue, la));
      case (eff)
        MODE_ALPHA: e.out_alpha = 8'((ta + ((la * filt_alpha) >> 8)) >> 1);
        MODE_LAYER: e.out_alpha = 8'((ta * (255 - la) + 255 * la) / 255);
        default:    e.out_alpha = 8'(ta);
      endcase
      pending = {pending, e};
    endfunction

    function void check_byte(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Compare a finished pixel against the oldest prediction
    function void check_result(plc_out_t r);
      plc_out_t e;
      if (pending.size() == 0) begin
        $error("pixel %h arrived with no request outstanding", r);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      compared++;
      check_byte("out_red", e.out_red, r.out_red);
      check_byte("out_green", e.out_green, r.out_green);
      check_byte("out_blue", e.out_blue, r.out_blue);
      check_byte("out_alpha", e.out_alpha, r.out_alpha);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  plc_in_t pixel;
  logic done;
  plc_out_t result;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blend_scoreboard tracker = new();
  int unsigned idle_cycles = 0;
  int unsigned settings = 0;

  pixel_layer_combiner u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Record accepted requests and check finished pixels
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.note_request(pixel);
      if (done) tracker.check_result(result);
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy && !rst) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic plc_in_t make_pixel(logic [7:0] tr, logic [7:0] tg, logic [7:0] tb,
                                         logic [7:0] ta, logic [7:0] lr, logic [7:0] lg,
                                         logic [7:0] lb, logic [7:0] la);
    return {tr, tg, tb, ta, lr, lg, lb, la};
  endfunction

  // Random byte leaning toward the ends of the range
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 3));
      3:       return 8'($urandom_range(252, 254));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_filter();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic plc_in_t rand_pixel();
    return make_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                      pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endfunction

  // Present one request, with a random gap ahead of it
  task automatic send_pixel(plc_in_t p, int unsigned idle_pct);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait for the pipeline to drain
  task automatic hold_off();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  // Program all registers; junk in the upper mode bits and, at random, a stray index
  task automatic set_config(logic [3:0] m, logic [7:0] fr, logic [7:0] fg,
                            logic [7:0] fb, logic [7:0] fa);
    logic [3:0] junk;
    logic [CFG_IDX_W-1:0] stray_idx;
    junk = 4'($urandom);
    write_reg(CFG_MODE, {junk, m});
    write_reg(CFG_FILTER_RED, fr);
    write_reg(CFG_FILTER_GREEN, fg);
    write_reg(CFG_FILTER_BLUE, fb);
    write_reg(CFG_FILTER_ALPHA, fa);
    if ($urandom_range(0, 1) == 0) begin
      stray_idx = CFG_IDX_W'($urandom_range(CFG_FILTER_ALPHA + 1, 2**CFG_IDX_W - 1));
      write_reg(stray_idx, 8'($urandom));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Two pixels per mode: one pushing past the top, one past the bottom
  task automatic directed_mode(logic [3:0] m);
    set_config(m, 8'd255, 8'd0, 8'd128, m[0] ? 8'd64 : 8'd255);
    send_pixel(make_pixel(200, 0, 255, 77, 255, 255, 100, 255), 0);
    send_pixel(make_pixel(10, 255, 1, 255, 250, 0, 254, 3), 0);
    hold_off();
  endtask

  initial begin
    int unsigned idle_pct;
    start = 1'b0;
    pixel = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: layer mode, opaque, transparent and half-covered layers
    send_pixel(make_pixel(0, 0, 0, 0, 255, 255, 255, 255), 0);
    send_pixel(make_pixel(255, 255, 255, 255, 0, 0, 0, 0), 0);
    send_pixel(make_pixel(200, 17, 90, 128, 100, 240, 3, 128), 0);
    hold_off();

    // Every mode, then a code past the defined ones
    for (int m = MODE_ADDCLAMP; m <= MODE_LAYER; m++) directed_mode(4'(m));
    directed_mode(MODE_CODE_UNUSED);

    // Random phases: light sender gaps, then heavy, then back to back
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      idle_pct = (ph < 6) ? 12 : (ph < 11) ? 70 : 0;
      set_config(4'((ph * 5) % 16), pick_filter(), pick_filter(), pick_filter(),
                 pick_filter());
      repeat (PHASE_ITEMS) begin
        send_pixel(rand_pixel(), idle_pct);
        if ($urandom_range(0, 99) == 0) hold_off();
      end
      hold_off();
    end

    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (tracker.pending.size() != 0) begin
      $error("%0d expected pixels never arrived", tracker.pending.size());
      tracker.mismatches++;
    end
    $display("Compared %0d pixels over %0d register settings,", tracker.compared, settings);
    $display("covering all nine modes, unused mode codes and filter extremes.");
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
